// ===== rtl/cau_pkg.sv =====
// Package for the complex arithmetic unit: opcodes, status codes,
// default widths and the control word passed between pipeline parts.
// No dependencies.
`default_nettype none
package cau_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 12;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef struct packed {
    logic vld;
    op_t  op;
  } ctl_t;

endpackage
`default_nettype wire

// ===== rtl/cau_front.sv =====
// Front end: stage 1 forms all products and the add/sub sums, stage 2
// combines products into sign/magnitude parts and the divisor |b|^2.
// Depends on cau_pkg.
`default_nettype none
module cau_front #(
  parameter int unsigned DW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_vld,
  input  wire logic [1:0]           in_op,
  input  wire logic signed [DW-1:0] a_re,
  input  wire logic signed [DW-1:0] a_im,
  input  wire logic signed [DW-1:0] b_re,
  input  wire logic signed [DW-1:0] b_im,
  output cau_pkg::ctl_t             ctl_o,
  output logic signed [DW:0]        as_re_o,
  output logic signed [DW:0]        as_im_o,
  output logic                      neg_re_o,
  output logic                      neg_im_o,
  output logic [2*DW-1:0]           mag_re_o,
  output logic [2*DW-1:0]           mag_im_o,
  output logic [2*DW-1:0]           den_o
);
  import cau_pkg::*;

  localparam int unsigned MW = 2 * DW;

  ctl_t                 ctl1_r, ctl2_r;
  logic signed [DW:0]   as_re1_r, as_im1_r, as_re2_r, as_im2_r;
  logic signed [MW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, d_rr_r, d_ii_r;
  logic signed [DW:0]   ar_x, ai_x, br_x, bi_x;
  logic signed [MW:0]   re_w, im_w;
  logic                 neg_re_r, neg_im_r;
  logic [MW-1:0]        mag_re_r, mag_im_r, den_r;

  assign ar_x = {a_re[DW-1], a_re};
  assign ai_x = {a_im[DW-1], a_im};
  assign br_x = {b_re[DW-1], b_re};
  assign bi_x = {b_im[DW-1], b_im};

  always_comb begin
    if (ctl1_r.op == OP_MUL) begin
      re_w = {p_rr_r[MW-1], p_rr_r} - {p_ii_r[MW-1], p_ii_r};
      im_w = {p_ri_r[MW-1], p_ri_r} + {p_ir_r[MW-1], p_ir_r};
    end else begin
      // divide: a * conj(b)
      re_w = {p_rr_r[MW-1], p_rr_r} + {p_ii_r[MW-1], p_ii_r};
      im_w = {p_ir_r[MW-1], p_ir_r} - {p_ri_r[MW-1], p_ri_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (en) begin
      ctl1_r <= '{vld: in_vld, op: op_t'(in_op)};
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      as_re1_r <= (op_t'(in_op) == OP_SUB) ? ar_x - br_x : ar_x + br_x;
      as_im1_r <= (op_t'(in_op) == OP_SUB) ? ai_x - bi_x : ai_x + bi_x;
      p_rr_r   <= MW'(a_re * b_re);
      p_ii_r   <= MW'(a_im * b_im);
      p_ri_r   <= MW'(a_re * b_im);
      p_ir_r   <= MW'(a_im * b_re);
      d_rr_r   <= MW'(b_re * b_re);
      d_ii_r   <= MW'(b_im * b_im);
      as_re2_r <= as_re1_r;
      as_im2_r <= as_im1_r;
      neg_re_r <= re_w[MW];
      neg_im_r <= im_w[MW];
      mag_re_r <= re_w[MW] ? MW'(-re_w) : re_w[MW-1:0];
      mag_im_r <= im_w[MW] ? MW'(-im_w) : im_w[MW-1:0];
      den_r    <= d_rr_r + d_ii_r;
    end
  end

  assign ctl_o    = ctl2_r;
  assign as_re_o  = as_re2_r;
  assign as_im_o  = as_im2_r;
  assign neg_re_o = neg_re_r;
  assign neg_im_o = neg_im_r;
  assign mag_re_o = mag_re_r;
  assign mag_im_o = mag_im_r;
  assign den_o    = den_r;

endmodule
`default_nettype wire

// ===== rtl/cau_div.sv =====
// Pipelined restoring divider: q = floor(mag * 2^F / den), one quotient
// bit per stage; ovf flags q >= 2^DW. No package dependencies.
`default_nettype none
module cau_div #(
  parameter int unsigned DW = 16,
  parameter int unsigned F  = 12
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [2*DW-1:0]   mag,
  input  wire logic [2*DW-1:0]   den,
  output logic      [DW-1:0]     q,
  output logic                   ovf
);
  localparam int unsigned MW = 2 * DW;
  localparam int unsigned CW = 3 * DW + F;

  logic [CW-1:0] rem_r [0:DW];
  logic [MW-1:0] den_r [0:DW];
  logic [DW-1:0] q_r   [0:DW];
  logic          ovf_r [0:DW];
  logic [CW-1:0] num_w, lim_w;

  assign num_w = CW'(mag) << F;
  assign lim_w = CW'(den) << DW;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_w;
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= (num_w >= lim_w);
    end
  end

  for (genvar k = 1; k <= DW; k++) begin : g_stage
    logic [CW-1:0] dsh;
    logic          take;
    assign dsh  = CW'(den_r[k-1]) << (DW - k);
    assign take = (rem_r[k-1] >= dsh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? rem_r[k-1] - dsh : rem_r[k-1];
        den_r[k] <= den_r[k-1];
        q_r[k]   <= q_r[k-1] | (take ? (DW'(1) << (DW - k)) : '0);
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign q   = q_r[DW];
  assign ovf = ovf_r[DW];

endmodule
`default_nettype wire

// ===== rtl/complex_arithmetic_unit.sv =====
// Complex add/sub/mul/div, Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS, saturating.
// 2 front stages, DATA_WIDTH + 1 divider stages, 1 output register;
// throughput one transaction per cycle while the output is not stalled.
// The pipeline advances as a whole whenever the output register is empty
// or being taken. Synchronous active-low reset clears all valid bits.
`default_nettype none
module complex_arithmetic_unit #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_opcode,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_re,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_im,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_re,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_res_re,
  output logic signed [DATA_WIDTH-1:0]      out_res_im,
  output logic [1:0]                        out_status
);
  import cau_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned MW = 2 * DW;
  localparam int unsigned DL = DW + 1;

  logic               en;
  ctl_t               f_ctl;
  logic signed [DW:0] f_as_re, f_as_im;
  logic               f_neg_re, f_neg_im;
  logic [MW-1:0]      f_mag_re, f_mag_im, f_den;
  logic [DW-1:0]      q_re, q_im;
  logic               ovf_re, ovf_im;

  ctl_t               d_ctl_r    [0:DL-1];
  logic signed [DW:0] d_as_re_r  [0:DL-1];
  logic signed [DW:0] d_as_im_r  [0:DL-1];
  logic               d_neg_re_r [0:DL-1];
  logic               d_neg_im_r [0:DL-1];
  logic [MW-1:0]      d_mag_re_r [0:DL-1];
  logic [MW-1:0]      d_mag_im_r [0:DL-1];
  logic               d_zero_r   [0:DL-1];

  logic                out_valid_r;
  logic [DW-1:0]       res_re_r, res_im_r, res_re_nxt, res_im_nxt;
  status_t             status_r, status_nxt;

  // returns {saturated, value}
  function automatic logic [DW:0] sat_sm(input logic neg, input logic [MW-1:0] m);
    logic [MW-1:0] maxp;
    maxp = (MW'(1) << (DW - 1)) - MW'(1);
    if (!neg) begin
      if (m > maxp) sat_sm = {1'b1, maxp[DW-1:0]};
      else          sat_sm = {1'b0, m[DW-1:0]};
    end else begin
      if (m > maxp + MW'(1)) sat_sm = {1'b1, 1'b1, {(DW-1){1'b0}}};
      else                   sat_sm = {1'b0, DW'(-m[DW-1:0])};
    end
  endfunction

  function automatic logic [MW-1:0] abs_as(input logic signed [DW:0] s);
    logic [DW:0] a;
    a = s[DW] ? -s : s;
    abs_as = MW'(a);
  endfunction

  assign en       = !out_valid_r || out_ready;
  // no transaction is taken while reset is held
  assign in_ready = en && rst_n;

  cau_front #(.DW(DW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_op    (in_opcode),
    .a_re     (in_a_re),
    .a_im     (in_a_im),
    .b_re     (in_b_re),
    .b_im     (in_b_im),
    .ctl_o    (f_ctl),
    .as_re_o  (f_as_re),
    .as_im_o  (f_as_im),
    .neg_re_o (f_neg_re),
    .neg_im_o (f_neg_im),
    .mag_re_o (f_mag_re),
    .mag_im_o (f_mag_im),
    .den_o    (f_den)
  );

  cau_div #(.DW(DW), .F(FRAC_BITS)) u_div_re (
    .clk (clk), .en (en), .mag (f_mag_re), .den (f_den), .q (q_re), .ovf (ovf_re)
  );

  cau_div #(.DW(DW), .F(FRAC_BITS)) u_div_im (
    .clk (clk), .en (en), .mag (f_mag_im), .den (f_den), .q (q_im), .ovf (ovf_im)
  );

  // side data travels alongside the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) d_ctl_r[i] <= '0;
    end else if (en) begin
      d_ctl_r[0] <= f_ctl;
      for (int i = 1; i < DL; i++) d_ctl_r[i] <= d_ctl_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_as_re_r[0]  <= f_as_re;
      d_as_im_r[0]  <= f_as_im;
      d_neg_re_r[0] <= f_neg_re;
      d_neg_im_r[0] <= f_neg_im;
      d_mag_re_r[0] <= f_mag_re;
      d_mag_im_r[0] <= f_mag_im;
      d_zero_r[0]   <= (f_den == '0);
      for (int i = 1; i < DL; i++) begin
        d_as_re_r[i]  <= d_as_re_r[i-1];
        d_as_im_r[i]  <= d_as_im_r[i-1];
        d_neg_re_r[i] <= d_neg_re_r[i-1];
        d_neg_im_r[i] <= d_neg_im_r[i-1];
        d_mag_re_r[i] <= d_mag_re_r[i-1];
        d_mag_im_r[i] <= d_mag_im_r[i-1];
        d_zero_r[i]   <= d_zero_r[i-1];
      end
    end
  end

  always_comb begin
    logic [DW:0]   sr, si;
    logic [MW-1:0] mr, mi;
    mr = '1;
    mi = '1;
    case (d_ctl_r[DL-1].op)
      OP_ADD, OP_SUB: begin
        sr = sat_sm(d_as_re_r[DL-1][DW], abs_as(d_as_re_r[DL-1]));
        si = sat_sm(d_as_im_r[DL-1][DW], abs_as(d_as_im_r[DL-1]));
      end
      OP_MUL: begin
        sr = sat_sm(d_neg_re_r[DL-1], d_mag_re_r[DL-1] >> FRAC_BITS);
        si = sat_sm(d_neg_im_r[DL-1], d_mag_im_r[DL-1] >> FRAC_BITS);
      end
      default: begin
        if (!ovf_re) mr = MW'(q_re);
        if (!ovf_im) mi = MW'(q_im);
        sr = sat_sm(d_neg_re_r[DL-1], mr);
        si = sat_sm(d_neg_im_r[DL-1], mi);
      end
    endcase
    res_re_nxt = sr[DW-1:0];
    res_im_nxt = si[DW-1:0];
    status_nxt = (sr[DW] || si[DW]) ? ST_SAT : ST_OK;
    if (d_ctl_r[DL-1].op == OP_DIV && d_zero_r[DL-1]) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      status_nxt = ST_DIV0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_ctl_r[DL-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_res_re = res_re_r;
  assign out_res_im = res_im_r;
  assign out_status = status_r;

endmodule
`default_nettype wire

// ===== rtl/cau_checker.sv =====
// Port-level checks for complex_arithmetic_unit, bound to the top level.
// Depends on cau_pkg.
`default_nettype none
module cau_checker #(
  parameter int unsigned DW = 16
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire logic [DW-1:0] out_res_re,
  input wire logic [DW-1:0] out_res_im,
  input wire logic [1:0]    out_status
);
  import cau_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_re)
      && $stable(out_res_im) && $stable(out_status))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != ST_RSVD)
    else $error("reserved status code");

  a_div0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DIV0 |-> out_res_re == '0 && out_res_im == '0)
    else $error("divide by zero with nonzero result");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

endmodule

bind complex_arithmetic_unit cau_checker #(.DW(DATA_WIDTH)) u_cau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_res_re (out_res_re),
  .out_res_im (out_res_im),
  .out_status (out_status)
);
`default_nettype wire

// ===== dv/tb_complex_arithmetic_unit.sv =====
// Testbench for complex_arithmetic_unit: random and directed add/sub/mul/div
// transactions, checked in order against an in-bench fixed-point predictor.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int N_RANDOM = 800;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 200;

  typedef struct {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    status_t              status;
  } cplx_result_t;

  class cau_scoreboard;
    cplx_result_t pending[$];
    int errors;
    int n_checked;

    function new();
      errors = 0;
      n_checked = 0;
    endfunction

    static function longint clamp(longint v, ref bit flag);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (DW - 1)) - 1;
      lo = -(longint'(1) <<< (DW - 1));
      if (v > hi) begin
        flag = 1;
        return hi;
      end
      if (v < lo) begin
        flag = 1;
        return lo;
      end
      return v;
    endfunction

    // Sum of products scaled back by FB, truncated toward zero.
    static function longint scale_prod(longint s);
      longint m;
      m = (s < 0) ? -s : s;
      m = m >>> FB;
      return (s < 0) ? -m : m;
    endfunction

    static function longint scale_quot(longint num, longint den);
      longint m;
      m = (num < 0) ? -num : num;
      m = (m <<< FB) / den;
      return (num < 0) ? -m : m;
    endfunction

    function void note_input(op_t op, logic signed [DW-1:0] a_re, logic signed [DW-1:0] a_im,
                             logic signed [DW-1:0] b_re, logic signed [DW-1:0] b_im);
      cplx_result_t r;
      longint ar, ai, br, bi, den, vr, vi;
      bit flag;
      ar = a_re;
      ai = a_im;
      br = b_re;
      bi = b_im;
      flag = 0;
      r.status = ST_OK;
      vr = 0;
      vi = 0;
      case (op)
        OP_ADD: begin
          vr = ar + br;
          vi = ai + bi;
        end
        OP_SUB: begin
          vr = ar - br;
          vi = ai - bi;
        end
        OP_MUL: begin
          vr = scale_prod(ar * br - ai * bi);
          vi = scale_prod(ar * bi + ai * br);
        end
        default: begin
          den = br * br + bi * bi;
          if (den == 0) begin
            r.status = ST_DIV0;
          end else begin
            vr = scale_quot(ar * br + ai * bi, den);
            vi = scale_quot(ai * br - ar * bi, den);
          end
        end
      endcase
      r.re = DW'(clamp(vr, flag));
      r.im = DW'(clamp(vi, flag));
      if (r.status == ST_OK && flag) r.status = ST_SAT;
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [DW-1:0] re, logic signed [DW-1:0] im,
                               logic [1:0] status);
      cplx_result_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result re=%0d im=%0d status=%0d", $time, re, im, status);
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (re !== e.re) begin
        errors++;
        $display("%0t: res_re mismatch expected %0d actual %0d", $time, e.re, re);
      end
      if (im !== e.im) begin
        errors++;
        $display("%0t: res_im mismatch expected %0d actual %0d", $time, e.im, im);
      end
      if (status !== e.status) begin
        errors++;
        $display("%0t: status mismatch expected %0d actual %0d", $time, e.status, status);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic signed [DW-1:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [DW-1:0] out_res_re, out_res_im;
  logic [1:0] out_status;

  cau_scoreboard sb = new();
  bit no_idle = 0;
  bit hold_req = 0;
  int idle_cycles = 0;
  int n_sent = 0;

  always #10 clk = ~clk;

  complex_arithmetic_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_a_re(in_a_re), .in_a_im(in_a_im), .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_res_re(out_res_re), .out_res_im(out_res_im), .out_status(out_status)
  );

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic send_op(op_t op, logic signed [DW-1:0] ar, logic signed [DW-1:0] ai,
                         logic signed [DW-1:0] br, logic signed [DW-1:0] bi);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_opcode <= op;
    in_a_re <= ar;
    in_a_im <= ai;
    in_b_re <= br;
    in_b_im <= bi;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, ar, ai, br, bi);
    n_sent++;
  endtask

  function automatic logic signed [DW-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return DW'($urandom_range(0, 64)) - 16'sd32;
      2: return DW'($urandom_range(0, 16384)) - 16'sd8192;
      default: return DW'($urandom());
    endcase
  endfunction

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_res_re, out_res_im, out_status);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    op_t op;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, every operation, saturation and zero divisor
    send_op(OP_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_op(OP_ADD, 16'sh1000, -16'sh0800, 16'sh0001, 16'sh0002);
    send_op(OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_op(OP_SUB, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0001);
    send_op(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_op(OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_op(OP_MUL, 16'sh1000, 16'sh0000, 16'sh1000, 16'sh0000);
    send_op(OP_MUL, -16'sh0001, 16'sh0000, 16'sh0001, 16'sh0000);
    send_op(OP_MUL, 16'sh2000, 16'sh1000, -16'sh0800, 16'sh3000);
    send_op(OP_DIV, 16'sh1000, 16'sh1000, 16'sh0000, 16'sh0000);
    send_op(OP_DIV, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000);
    send_op(OP_DIV, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000);
    send_op(OP_DIV, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0001);
    send_op(OP_DIV, 16'sh1000, 16'sh0000, 16'sh1000, 16'sh0000);
    send_op(OP_DIV, -16'sh1000, 16'sh0003, 16'sh7fff, 16'sh7fff);
    send_op(OP_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_op(OP_DIV, 16'sh0001, -16'sh0001, 16'sh0003, -16'sh0007);
    send_op(OP_DIV, 16'sh0000, 16'sh0000, -16'sh0001, 16'sh0000);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 200) hold_req = 1;
      if (i == 400) begin
        in_valid <= 0;
        wait_drained();
      end
      no_idle = (i >= 550 && i < 650);
      op = op_t'($urandom_range(0, 3));
      if (op == OP_DIV && $urandom_range(0, 15) == 0)
        send_op(op, rand_operand(), rand_operand(), '0, '0);
      else
        send_op(op, rand_operand(), rand_operand(), rand_operand(), rand_operand());
    end
    in_valid <= 0;
    wait_drained();
    repeat (3 * (DW + 4)) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results (all four ops, saturation, zero divisor,",
             n_sent, sb.n_checked);
    $display("random back-pressure, one long output hold-off and one drain pause).");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
